/* rtl/cqi_pkg.sv */
// Package for the indexed circular queue: field widths, default sizes,
// request kind codes and status codes. No dependencies.
`default_nettype none

package cqi_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int DATA_W_DEF = 32;

    localparam int KIND_W = 3;
    localparam int POS_W  = 4;
    localparam int CAP_W  = 5;
    localparam int CNT_W  = 5;
    localparam int STAT_W = 2;

    localparam int CAP_RESET = 16;

    localparam logic [KIND_W-1:0] K_APPEND = 3'd0;
    localparam logic [KIND_W-1:0] K_PEEK   = 3'd1;
    localparam logic [KIND_W-1:0] K_POP    = 3'd2;
    localparam logic [KIND_W-1:0] K_READ   = 3'd3;
    localparam logic [KIND_W-1:0] K_DELETE = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

/* rtl/cqi_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module cqi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/cqi_wrap.sv */
// Shared ring-index adder: base plus offset, folded back once by the capacity.
// Depends on cqi_pkg.
`default_nettype none

module cqi_wrap
    import cqi_pkg::*;
#(
    parameter int PTR_W = 4
) (
    input  wire logic [PTR_W-1:0] i_base,
    input  wire logic [POS_W-1:0] i_off,
    input  wire logic [CAP_W-1:0] i_cap,
    output logic      [PTR_W-1:0] o_sum
);

    localparam int SUM_W = ((PTR_W > CAP_W) ? PTR_W : CAP_W) + 1;

    logic [SUM_W-1:0] raw;
    logic [SUM_W-1:0] folded;

    always_comb begin
        raw = SUM_W'(i_base) + SUM_W'(i_off);
        if (raw >= SUM_W'(i_cap)) begin
            folded = raw - SUM_W'(i_cap);
        end else begin
            folded = raw;
        end
        o_sum = folded[PTR_W-1:0];
    end

endmodule

`default_nettype wire

/* rtl/cqi_seq.sv */
// Request sequencer: pointers, count, output register and the shifting pass
// of a deletion. Depends on cqi_pkg; drives the slot RAM and the ring adder.
`default_nettype none

module cqi_seq
    import cqi_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_W_DEF,
    parameter int PTR_W      = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [KIND_W-1:0]     i_kind,
    input  wire logic [DATA_WIDTH-1:0] i_push_data,
    input  wire logic [POS_W-1:0]      i_position,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic      [STAT_W-1:0]     o_status,
    output logic      [DATA_WIDTH-1:0] o_read_data,
    output logic      [CNT_W-1:0]      o_entry_count,
    input  wire logic                  i_cfg_pending,
    input  wire logic                  i_cfg_clear,
    input  wire logic [CAP_W-1:0]      i_capacity,
    output logic                       o_idle,
    output logic                       o_ram_we,
    output logic      [PTR_W-1:0]      o_ram_waddr,
    output logic      [DATA_WIDTH-1:0] o_ram_wdata,
    output logic                       o_ram_re,
    output logic      [PTR_W-1:0]      o_ram_raddr,
    input  wire logic [DATA_WIDTH-1:0] i_ram_rdata,
    output logic      [PTR_W-1:0]      o_wrap_base,
    output logic      [POS_W-1:0]      o_wrap_off,
    input  wire logic [PTR_W-1:0]      i_wrap_sum
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_OUT
    } t_state;

    t_state                r_state,  n_state;
    logic [KIND_W-1:0]     r_kind,   n_kind;
    logic [DATA_WIDTH-1:0] r_data,   n_data;
    logic [POS_W-1:0]      r_pos,    n_pos;
    logic [PTR_W-1:0]      r_head,   n_head;
    logic [PTR_W-1:0]      r_tail,   n_tail;
    logic [CNT_W-1:0]      r_count,  n_count;
    logic [PTR_W-1:0]      r_at,     n_at;
    logic [PTR_W-1:0]      r_nx,     n_nx;
    logic [CNT_W-1:0]      r_moves,  n_moves;
    logic [STAT_W-1:0]     r_status, n_status;
    logic [DATA_WIDTH-1:0] r_rd,     n_rd;
    logic                  r_out_valid, n_out_valid;
    logic [STAT_W-1:0]     r_out_status, n_out_status;
    logic [DATA_WIDTH-1:0] r_out_rd,     n_out_rd;
    logic [CNT_W-1:0]      r_out_count,  n_out_count;

    logic accept;
    logic out_free;

    assign o_idle        = (r_state == S_IDLE);
    assign o_stall       = (r_state != S_IDLE) || i_cfg_pending;
    assign accept        = i_valid && !o_stall;
    assign out_free      = !r_out_valid || !i_stall;
    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_read_data   = r_out_rd;
    assign o_entry_count = r_out_count;

    always_comb begin
        o_wrap_base = r_tail;
        o_wrap_off  = POS_W'(1);
        unique case (r_state)
            S_EXEC: begin
                if (r_kind == K_POP) begin
                    o_wrap_base = r_head;
                end else if (r_kind == K_READ || r_kind == K_DELETE) begin
                    o_wrap_base = r_head;
                    o_wrap_off  = r_pos;
                end
            end
            S_SHIFT_RD: begin
                o_wrap_base = r_at;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_data       = r_data;
        n_pos        = r_pos;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_at         = r_at;
        n_nx         = r_nx;
        n_moves      = r_moves;
        n_status     = r_status;
        n_rd         = r_rd;
        n_out_valid  = r_out_valid && i_stall;
        n_out_status = r_out_status;
        n_out_rd     = r_out_rd;
        n_out_count  = r_out_count;
        o_ram_we     = 1'b0;
        o_ram_waddr  = r_tail;
        o_ram_wdata  = r_data;
        o_ram_re     = 1'b0;
        o_ram_raddr  = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_clear) begin
                    n_head  = '0;
                    n_tail  = '0;
                    n_count = '0;
                end
                if (accept) begin
                    n_kind  = i_kind;
                    n_data  = i_push_data;
                    n_pos   = i_position;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status = ST_OK;
                n_rd     = '0;
                n_state  = S_OUT;
                unique case (r_kind)
                    K_APPEND: begin
                        if (r_count >= i_capacity) begin
                            n_status = ST_FULL;
                        end else begin
                            o_ram_we = 1'b1;
                            n_tail   = i_wrap_sum;
                            n_count  = r_count + CNT_W'(1);
                        end
                    end
                    K_PEEK, K_POP: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            o_ram_re = 1'b1;
                            n_state  = S_READ;
                            if (r_kind == K_POP) begin
                                n_head  = i_wrap_sum;
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                    end
                    K_READ, K_DELETE: begin
                        if (CNT_W'(r_pos) >= r_count) begin
                            n_status = ST_EMPTY;
                        end else begin
                            o_ram_re    = 1'b1;
                            o_ram_raddr = i_wrap_sum;
                            n_at        = i_wrap_sum;
                            n_moves     = r_count - CNT_W'(r_pos) - CNT_W'(1);
                            n_state     = S_READ;
                        end
                    end
                    default: begin
                        n_status = ST_EMPTY;
                    end
                endcase
            end
            S_READ: begin
                n_rd    = i_ram_rdata;
                n_state = S_OUT;
                if (r_kind == K_DELETE) begin
                    n_count = r_count - CNT_W'(1);
                    if (r_moves == '0) begin
                        n_tail = r_at;
                    end else begin
                        n_state = S_SHIFT_RD;
                    end
                end
            end
            S_SHIFT_RD: begin
                o_ram_re    = 1'b1;
                o_ram_raddr = i_wrap_sum;
                n_nx        = i_wrap_sum;
                n_state     = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_at;
                o_ram_wdata = i_ram_rdata;
                n_at        = r_nx;
                n_moves     = r_moves - CNT_W'(1);
                if (r_moves == CNT_W'(1)) begin
                    n_tail  = r_nx;
                    n_state = S_OUT;
                end else begin
                    n_state = S_SHIFT_RD;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_rd     = r_rd;
                    n_out_count  = r_count;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_kind       <= n_kind;
        r_data       <= n_data;
        r_pos        <= n_pos;
        r_at         <= n_at;
        r_nx         <= n_nx;
        r_moves      <= n_moves;
        r_status     <= n_status;
        r_rd         <= n_rd;
        r_out_status <= n_out_status;
        r_out_rd     <= n_out_rd;
        r_out_count  <= n_out_count;
    end

endmodule

`default_nettype wire

/* rtl/circular_queue_indexed.sv */
// Indexed circular queue. Append and error requests pass the execute and output
// states, peek, pop and read also a RAM read state, and a deletion a read and a
// write state per later entry that moves down, set by the single RAM read port
// and the one shared ring adder. A result is valid from the same cycle as the
// next word can be taken, if no config write is pending. Reset empties the queue
// and sets the capacity to 16 (or the depth, if smaller); slot data is not cleared.
`default_nettype none

module circular_queue_indexed
    import cqi_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_W_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [KIND_W-1:0]     i_kind,
    input  wire logic [DATA_WIDTH-1:0] i_push_data,
    input  wire logic [POS_W-1:0]      i_position,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic      [STAT_W-1:0]     o_status,
    output logic      [DATA_WIDTH-1:0] o_read_data,
    output logic      [CNT_W-1:0]      o_entry_count,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CAP_W-1:0]      i_cfg_data
);

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CAP_DEF = (CAP_RESET > DEPTH) ? DEPTH : CAP_RESET;

    logic [CAP_W-1:0]      r_capacity, n_capacity;
    logic                  idle;
    logic                  cfg_write;
    logic                  ram_we;
    logic [PTR_W-1:0]      ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [PTR_W-1:0]      ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic [PTR_W-1:0]      wrap_base;
    logic [POS_W-1:0]      wrap_off;
    logic [PTR_W-1:0]      wrap_sum;

    assign o_cfg_ready = idle;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    // A capacity of zero is taken as one, and anything above the depth as the depth.
    always_comb begin
        n_capacity = r_capacity;
        if (cfg_write) begin
            if (i_cfg_data == '0) begin
                n_capacity = CAP_W'(1);
            end else if (int'(i_cfg_data) > DEPTH) begin
                n_capacity = CAP_W'(DEPTH);
            end else begin
                n_capacity = i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_W'(CAP_DEF);
        end else begin
            r_capacity <= n_capacity;
        end
    end

    cqi_seq #(
        .DATA_WIDTH (DATA_WIDTH),
        .PTR_W      (PTR_W)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_push_data   (i_push_data),
        .i_position    (i_position),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_read_data   (o_read_data),
        .o_entry_count (o_entry_count),
        .i_cfg_pending (i_cfg_valid),
        .i_cfg_clear   (cfg_write),
        .i_capacity    (r_capacity),
        .o_idle        (idle),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_re      (ram_re),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata),
        .o_wrap_base   (wrap_base),
        .o_wrap_off    (wrap_off),
        .i_wrap_sum    (wrap_sum)
    );

    cqi_wrap #(
        .PTR_W (PTR_W)
    ) u_wrap (
        .i_base (wrap_base),
        .i_off  (wrap_off),
        .i_cap  (r_capacity),
        .o_sum  (wrap_sum)
    );

    cqi_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire
